// ===== src/vcrf_pkg.sv =====
// ----------------------------------------------------------------------------
// Video chip register file package
// Register addresses, action codes, field widths and sizes shared by the
// register bank and its checker.
// ----------------------------------------------------------------------------
package vcrf_pkg;

  localparam int NumSprites = 8;
  localparam int MaxSprites = 8;
  localparam int PaletteDepth = 15;

  localparam int AddrW = 6;
  localparam int ActionW = 2;
  localparam int InDataW = 64;
  localparam int OutDataW = 40;

  localparam logic [ActionW-1:0] ActRead = 2'd0;
  localparam logic [ActionW-1:0] ActWrite = 2'd1;
  localparam logic [ActionW-1:0] ActEvent = 2'd2;

  localparam logic [AddrW-1:0] RegPosFirst = 6'h00;
  localparam logic [AddrW-1:0] RegPosLast = 6'h0f;
  localparam logic [AddrW-1:0] RegMsbX = 6'h10;
  localparam logic [AddrW-1:0] RegCtrlOne = 6'h11;
  localparam logic [AddrW-1:0] RegRaster = 6'h12;
  localparam logic [AddrW-1:0] RegPenX = 6'h13;
  localparam logic [AddrW-1:0] RegPenY = 6'h14;
  localparam logic [AddrW-1:0] RegSpriteOn = 6'h15;
  localparam logic [AddrW-1:0] RegCtrlTwo = 6'h16;
  localparam logic [AddrW-1:0] RegStretchY = 6'h17;
  localparam logic [AddrW-1:0] RegPointers = 6'h18;
  localparam logic [AddrW-1:0] RegIrqLatch = 6'h19;
  localparam logic [AddrW-1:0] RegIrqEnable = 6'h1a;
  localparam logic [AddrW-1:0] RegBehind = 6'h1b;
  localparam logic [AddrW-1:0] RegMulti = 6'h1c;
  localparam logic [AddrW-1:0] RegStretchX = 6'h1d;
  localparam logic [AddrW-1:0] RegHitSprite = 6'h1e;
  localparam logic [AddrW-1:0] RegHitBackdrop = 6'h1f;
  localparam logic [AddrW-1:0] RegPaletteFirst = 6'h20;
  localparam logic [AddrW-1:0] RegPaletteLast = 6'h2e;

endpackage

// ===== src/video_chip_register_file_core.sv =====
// ----------------------------------------------------------------------------
// Video chip register file core
// Register bank of an eight-sprite video chip: bus reads, bus writes and
// collision/interrupt events, one result per transaction.
// ----------------------------------------------------------------------------
// Every input transaction produces exactly one result transaction, registered in
// the input register and then the result register. One transaction is taken per
// cycle while the output is not stalled: the input register feeds a single pass of
// decode and select logic that updates the bank and loads the result register.
// Reads fill unused bits with ones, collision registers clear on read, and the
// display settings in each result reflect the bank after that transaction.
module video_chip_register_file_core
  import vcrf_pkg::*;
#(
  parameter int SPRITES = NumSprites
) (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // addr[5:0], wdata[13:6], raster_line[22:14], pen_x[30:23], pen_y[38:31],
  // sprite_hits[46:39], backdrop_hits[54:47], irq_events[58:55], zeros above
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [ActionW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // rdata[7:0], compare_line[16:8], irq_active[17], display_on[18],
  // scroll_y[21:19], scroll_x[24:22], video_mode[27:25], wide_columns[28],
  // tall_rows[29], matrix_base[33:30], glyph_base[36:34], zeros above
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                clk_i,
  input  logic                rst_ni
);

  localparam logic [7:0] SprMask = 8'((16'd1 << SPRITES) - 16'd1);
  localparam logic [7:0] SprFill = ~SprMask;

  logic                in_valid_q;
  logic [ActionW-1:0]  action_q;
  logic [AddrW-1:0]    addr_q;
  logic [7:0]          wdata_q;
  logic [8:0]          raster_q;
  logic [7:0]          pen_x_q;
  logic [7:0]          pen_y_q;
  logic [7:0]          sprite_hits_q;
  logic [7:0]          backdrop_hits_q;
  logic [3:0]          irq_events_q;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] out_data_d;

  logic [8:0] pos_x_q [MaxSprites];
  logic [8:0] pos_x_d [MaxSprites];
  logic [7:0] pos_y_q [MaxSprites];
  logic [7:0] pos_y_d [MaxSprites];
  logic [3:0] palette_q [PaletteDepth];
  logic [3:0] palette_d [PaletteDepth];

  logic [7:0] sprite_on_q, sprite_on_d;
  logic [7:0] stretch_y_q, stretch_y_d;
  logic [7:0] stretch_x_q, stretch_x_d;
  logic [7:0] behind_q, behind_d;
  logic [7:0] multi_q, multi_d;
  logic [7:0] ctrl_one_q, ctrl_one_d;
  logic [7:0] ctrl_two_q, ctrl_two_d;
  logic [6:0] pointers_q, pointers_d;
  logic [3:0] latch_q, latch_d;
  logic [3:0] enable_q, enable_d;
  logic [8:0] compare_q, compare_d;
  logic [7:0] hit_sprite_q, hit_sprite_d;
  logic [7:0] hit_backdrop_q, hit_backdrop_d;
  logic [1:0] armed_q, armed_d;

  logic       advance;
  logic [2:0] spr_idx;
  logic       spr_present;
  logic [3:0] pal_idx;
  logic [7:0] msb_x;
  logic [7:0] rdata;
  logic [7:0] sh_masked;
  logic [7:0] bh_masked;
  logic       irq_active;

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  assign spr_idx = addr_q[3:1];
  assign spr_present = ({1'b0, spr_idx} < 4'(SPRITES));
  assign pal_idx = addr_q[3:0];
  assign sh_masked = sprite_hits_q & SprMask;
  assign bh_masked = backdrop_hits_q & SprMask;

  always_comb begin
    for (int i = 0; i < MaxSprites; i++) begin
      msb_x[i] = pos_x_q[i][8];
    end
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    palette_d = palette_q;
    sprite_on_d = sprite_on_q;
    stretch_y_d = stretch_y_q;
    stretch_x_d = stretch_x_q;
    behind_d = behind_q;
    multi_d = multi_q;
    ctrl_one_d = ctrl_one_q;
    ctrl_two_d = ctrl_two_q;
    pointers_d = pointers_q;
    latch_d = latch_q;
    enable_d = enable_q;
    compare_d = compare_q;
    hit_sprite_d = hit_sprite_q;
    hit_backdrop_d = hit_backdrop_q;
    armed_d = armed_q;
    rdata = 8'h00;

    case (action_q)
      ActRead: begin
        case (addr_q) inside
          [RegPosFirst:RegPosLast]: begin
            if (!spr_present) begin
              rdata = 8'hff;
            end else if (addr_q[0]) begin
              rdata = pos_y_q[spr_idx];
            end else begin
              rdata = pos_x_q[spr_idx][7:0];
            end
          end
          [RegPaletteFirst:RegPaletteLast]: rdata = {4'hf, palette_q[pal_idx]};
          RegMsbX:        rdata = (msb_x & SprMask) | SprFill;
          RegCtrlOne:     rdata = {raster_q[8], ctrl_one_q[6:0]};
          RegRaster:      rdata = raster_q[7:0];
          RegPenX:        rdata = pen_x_q;
          RegPenY:        rdata = pen_y_q;
          RegSpriteOn:    rdata = sprite_on_q | SprFill;
          RegCtrlTwo:     rdata = ctrl_two_q | 8'hc0;
          RegStretchY:    rdata = stretch_y_q | SprFill;
          RegPointers:    rdata = {pointers_q, 1'b1};
          RegIrqLatch:    rdata = {|(latch_q & enable_q), 3'b111, latch_q};
          RegIrqEnable:   rdata = {4'hf, enable_q};
          RegBehind:      rdata = behind_q | SprFill;
          RegMulti:       rdata = multi_q | SprFill;
          RegStretchX:    rdata = stretch_x_q | SprFill;
          RegHitSprite: begin
            rdata = hit_sprite_q | SprFill;
            hit_sprite_d = 8'h00;
            armed_d[0] = 1'b1;
          end
          RegHitBackdrop: begin
            rdata = hit_backdrop_q | SprFill;
            hit_backdrop_d = 8'h00;
            armed_d[1] = 1'b1;
          end
          default:        rdata = 8'hff;
        endcase
      end
      ActWrite: begin
        case (addr_q) inside
          [RegPosFirst:RegPosLast]: begin
            if (spr_present) begin
              if (addr_q[0]) begin
                pos_y_d[spr_idx] = wdata_q;
              end else begin
                pos_x_d[spr_idx] = {pos_x_q[spr_idx][8], wdata_q};
              end
            end
          end
          [RegPaletteFirst:RegPaletteLast]: palette_d[pal_idx] = wdata_q[3:0];
          RegMsbX: begin
            for (int i = 0; i < MaxSprites; i++) begin
              if (SprMask[i]) begin
                pos_x_d[i] = {wdata_q[i], pos_x_q[i][7:0]};
              end
            end
          end
          RegCtrlOne: begin
            ctrl_one_d = wdata_q;
            compare_d = {wdata_q[7], compare_q[7:0]};
          end
          RegRaster:      compare_d = {compare_q[8], wdata_q};
          RegSpriteOn:    sprite_on_d = wdata_q & SprMask;
          RegCtrlTwo:     ctrl_two_d = wdata_q;
          RegStretchY:    stretch_y_d = wdata_q & SprMask;
          RegPointers:    pointers_d = wdata_q[7:1];
          RegIrqLatch:    latch_d = latch_q & ~wdata_q[3:0];
          RegIrqEnable:   enable_d = wdata_q[3:0];
          RegBehind:      behind_d = wdata_q & SprMask;
          RegMulti:       multi_d = wdata_q & SprMask;
          RegStretchX:    stretch_x_d = wdata_q & SprMask;
          default: ;
        endcase
      end
      ActEvent: begin
        hit_sprite_d = hit_sprite_q | sh_masked;
        hit_backdrop_d = hit_backdrop_q | bh_masked;
        latch_d = latch_q | irq_events_q;
        if ((sh_masked != 8'h00) && armed_q[0]) begin
          latch_d[2] = 1'b1;
          armed_d[0] = 1'b0;
        end
        if ((bh_masked != 8'h00) && armed_q[1]) begin
          latch_d[1] = 1'b1;
          armed_d[1] = 1'b0;
        end
      end
      default: ;
    endcase

    irq_active = |(latch_d & enable_d);
    out_data_d = {3'b000, pointers_d[2:0], pointers_d[6:3], ctrl_one_d[3], ctrl_two_d[3],
                  ctrl_one_d[6:5], ctrl_two_d[4], ctrl_two_d[2:0], ctrl_one_d[2:0],
                  ctrl_one_d[4], irq_active, compare_d, rdata};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      action_q <= s_axis_tuser;
      addr_q <= s_axis_tdata[5:0];
      wdata_q <= s_axis_tdata[13:6];
      raster_q <= s_axis_tdata[22:14];
      pen_x_q <= s_axis_tdata[30:23];
      pen_y_q <= s_axis_tdata[38:31];
      sprite_hits_q <= s_axis_tdata[46:39];
      backdrop_hits_q <= s_axis_tdata[54:47];
      irq_events_q <= s_axis_tdata[58:55];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxSprites; i++) begin
        pos_x_q[i] <= '0;
        pos_y_q[i] <= '0;
      end
      for (int i = 0; i < PaletteDepth; i++) begin
        palette_q[i] <= '0;
      end
      sprite_on_q <= '0;
      stretch_y_q <= '0;
      stretch_x_q <= '0;
      behind_q <= '0;
      multi_q <= '0;
      ctrl_one_q <= '0;
      ctrl_two_q <= '0;
      pointers_q <= '0;
      latch_q <= '0;
      enable_q <= '0;
      compare_q <= '0;
      hit_sprite_q <= '0;
      hit_backdrop_q <= '0;
      armed_q <= 2'b11;
    end else if (advance) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      palette_q <= palette_d;
      sprite_on_q <= sprite_on_d;
      stretch_y_q <= stretch_y_d;
      stretch_x_q <= stretch_x_d;
      behind_q <= behind_d;
      multi_q <= multi_d;
      ctrl_one_q <= ctrl_one_d;
      ctrl_two_q <= ctrl_two_d;
      pointers_q <= pointers_d;
      latch_q <= latch_d;
      enable_q <= enable_d;
      compare_q <= compare_d;
      hit_sprite_q <= hit_sprite_d;
      hit_backdrop_q <= hit_backdrop_d;
      armed_q <= armed_d;
    end
  end

endmodule

// ===== src/vcrf_checker.sv =====
// ----------------------------------------------------------------------------
// Video chip register file checker
// Port-level checks on flow control and latency of the register file core.
// ----------------------------------------------------------------------------
module vcrf_checker
  import vcrf_pkg::*;
(
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                clk_i,
  input logic                rst_ni
);

  // With no result waiting, the core can always take a new transaction.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while no result was pending");

  // A result that is not taken stays on the port unchanged.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result dropped or changed");

  // An accepted transaction yields a valid result once the output is ready while it is held in the input register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after accepted transaction");

  // Unused high bits of a valid result are always zero.
  a_result_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:37] == 3'b000)
    else $error("result padding bits not zero");

endmodule

bind video_chip_register_file_core vcrf_checker u_vcrf_checker (
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .clk_i        (clk_i),
  .rst_ni       (rst_ni)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Video chip register file testbench
// Drives bus reads, bus writes, collision/interrupt events and unknown actions
// into the register bank. A scoreboard keeps its own copy of the bank, works
// out the expected result of every accepted transaction, and compares each
// returned result field by field. Both sides stall at random, with one long
// output hold-off and one full drain of the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  import vcrf_pkg::*;

  localparam logic [ActionW-1:0] ActUnknown = 2'd3;
  localparam logic [AddrW-1:0] RegUnusedLast = 6'h3f;
  localparam logic [7:0] SpriteMask = 8'((1 << NumSprites) - 1);
  localparam logic [7:0] SpriteFill = ~SpriteMask;
  localparam int RandomItems = 2000;
  localparam int CalmItems = 150;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles = 16;
  localparam int CycleLimit = 400000;
  localparam int PrintLimit = 100;

  typedef struct {
    logic [ActionW-1:0] action;
    logic [AddrW-1:0]   addr;
    logic [7:0]         wdata;
    logic [8:0]         line;
    logic [7:0]         pen_x;
    logic [7:0]         pen_y;
    logic [7:0]         sprite_hits;
    logic [7:0]         backdrop_hits;
    logic [3:0]         irq_events;
  } bus_op_t;

  typedef struct {
    logic [7:0] rdata;
    logic [8:0] compare_line;
    logic       irq_active;
    logic       display_on;
    logic [2:0] scroll_y;
    logic [2:0] scroll_x;
    logic [2:0] video_mode;
    logic       wide_columns;
    logic       tall_rows;
    logic [3:0] matrix_base;
    logic [2:0] glyph_base;
  } bank_result_t;

  class register_bank_checker;
    logic [8:0] pos_x[MaxSprites];
    logic [7:0] pos_y[MaxSprites];
    logic [7:0] sprite_on, stretch_y, stretch_x, behind_bits, multi_bits;
    logic [7:0] ctrl_one, ctrl_two;
    logic [6:0] pointers;
    logic [7:0] latch_bits;
    logic [3:0] enable_bits;
    logic [8:0] compare_reg;
    logic [7:0] hit_sprite, hit_backdrop;
    logic [1:0] hit_armed;
    logic [3:0] palette[PaletteDepth];
    bank_result_t awaited_results[$];
    int errors, n_reads, n_writes, n_events, n_unknown, n_irq, n_hit_reads;

    function new();
      for (int i = 0; i < MaxSprites; i++) begin
        pos_x[i] = '0;
        pos_y[i] = '0;
      end
      for (int i = 0; i < PaletteDepth; i++) palette[i] = '0;
      sprite_on = '0; stretch_y = '0; stretch_x = '0; behind_bits = '0; multi_bits = '0;
      ctrl_one = '0; ctrl_two = '0; pointers = '0;
      latch_bits = '0; enable_bits = '0; compare_reg = '0;
      hit_sprite = '0; hit_backdrop = '0; hit_armed = 2'b11;
      errors = 0; n_reads = 0; n_writes = 0; n_events = 0; n_unknown = 0;
      n_irq = 0; n_hit_reads = 0;
    endfunction

    function bank_result_t predict_bank_step(bus_op_t op);
      bank_result_t r;
      logic [7:0] rd;
      logic [7:0] msb;
      logic [7:0] sh, bh;
      int idx;
      int pal;
      rd = '0;
      idx = int'(op.addr >> 1);
      pal = int'(op.addr) - int'(RegPaletteFirst);
      case (op.action)
        ActRead: begin
          if (op.addr <= RegPosLast) begin
            if (idx >= NumSprites) rd = 8'hff;
            else rd = op.addr[0] ? pos_y[idx] : pos_x[idx][7:0];
          end else if (op.addr >= RegPaletteFirst && op.addr <= RegPaletteLast) begin
            rd = {4'hf, palette[pal]};
          end else begin
            case (op.addr)
              RegMsbX: begin
                for (int i = 0; i < 8; i++) msb[i] = pos_x[i][8];
                rd = (msb & SpriteMask) | SpriteFill;
              end
              RegCtrlOne: rd = {op.line[8], ctrl_one[6:0]};
              RegRaster: rd = op.line[7:0];
              RegPenX: rd = op.pen_x;
              RegPenY: rd = op.pen_y;
              RegSpriteOn: rd = sprite_on | SpriteFill;
              RegCtrlTwo: rd = ctrl_two | 8'hc0;
              RegStretchY: rd = stretch_y | SpriteFill;
              RegPointers: rd = {pointers, 1'b1};
              RegIrqLatch: rd = latch_bits | 8'h70;
              RegIrqEnable: rd = {4'hf, enable_bits};
              RegBehind: rd = behind_bits | SpriteFill;
              RegMulti: rd = multi_bits | SpriteFill;
              RegStretchX: rd = stretch_x | SpriteFill;
              RegHitSprite: begin
                rd = hit_sprite | SpriteFill;
                hit_sprite = '0;
                hit_armed[0] = 1'b1;
                n_hit_reads++;
              end
              RegHitBackdrop: begin
                rd = hit_backdrop | SpriteFill;
                hit_backdrop = '0;
                hit_armed[1] = 1'b1;
                n_hit_reads++;
              end
              default: rd = 8'hff;
            endcase
          end
        end
        ActWrite: begin
          if (op.addr <= RegPosLast) begin
            if (idx < NumSprites) begin
              if (op.addr[0]) pos_y[idx] = op.wdata;
              else pos_x[idx][7:0] = op.wdata;
            end
          end else if (op.addr >= RegPaletteFirst && op.addr <= RegPaletteLast) begin
            palette[pal] = op.wdata[3:0];
          end else begin
            case (op.addr)
              RegMsbX: begin
                for (int i = 0; i < NumSprites; i++) pos_x[i][8] = op.wdata[i];
              end
              RegCtrlOne: begin
                ctrl_one = op.wdata;
                compare_reg[8] = op.wdata[7];
              end
              RegRaster: compare_reg[7:0] = op.wdata;
              RegSpriteOn: sprite_on = op.wdata & SpriteMask;
              RegCtrlTwo: ctrl_two = op.wdata;
              RegStretchY: stretch_y = op.wdata & SpriteMask;
              RegPointers: pointers = op.wdata[7:1];
              RegIrqLatch: latch_bits = latch_bits & ~{4'h0, op.wdata[3:0]} & 8'h0f;
              RegIrqEnable: enable_bits = op.wdata[3:0];
              RegBehind: behind_bits = op.wdata & SpriteMask;
              RegMulti: multi_bits = op.wdata & SpriteMask;
              RegStretchX: stretch_x = op.wdata & SpriteMask;
              default: ;
            endcase
          end
        end
        ActEvent: begin
          sh = op.sprite_hits & SpriteMask;
          bh = op.backdrop_hits & SpriteMask;
          hit_sprite = hit_sprite | sh;
          hit_backdrop = hit_backdrop | bh;
          latch_bits = latch_bits | {4'h0, op.irq_events};
          if (sh != 0 && hit_armed[0]) begin
            latch_bits[2] = 1'b1;
            hit_armed[0] = 1'b0;
          end
          if (bh != 0 && hit_armed[1]) begin
            latch_bits[1] = 1'b1;
            hit_armed[1] = 1'b0;
          end
        end
        default: ;
      endcase
      latch_bits = latch_bits & 8'h0f;
      if ((latch_bits[3:0] & enable_bits) != 0) latch_bits[7] = 1'b1;

      r.rdata = rd;
      r.compare_line = compare_reg;
      r.irq_active = latch_bits[7];
      r.display_on = ctrl_one[4];
      r.scroll_y = ctrl_one[2:0];
      r.scroll_x = ctrl_two[2:0];
      r.video_mode = {ctrl_one[6], ctrl_one[5], ctrl_two[4]};
      r.wide_columns = ctrl_two[3];
      r.tall_rows = ctrl_one[3];
      r.matrix_base = pointers[6:3];
      r.glyph_base = pointers[2:0];
      return r;
    endfunction

    function void note_request(bus_op_t op);
      case (op.action)
        ActRead: n_reads++;
        ActWrite: n_writes++;
        ActEvent: n_events++;
        default: n_unknown++;
      endcase
      awaited_results.push_back(predict_bank_step(op));
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PrintLimit) $display("mismatch %0d: %s", errors, msg);
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_response(logic [OutDataW-1:0] got);
      bank_result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result 0x%0h arrived with no request outstanding", got));
        return;
      end
      want = awaited_results.pop_front();
      if (want.irq_active) n_irq++;
      compare_field("rdata", got[7:0], want.rdata);
      compare_field("compare_line", got[16:8], want.compare_line);
      compare_field("irq_active", got[17], want.irq_active);
      compare_field("display_on", got[18], want.display_on);
      compare_field("scroll_y", got[21:19], want.scroll_y);
      compare_field("scroll_x", got[24:22], want.scroll_x);
      compare_field("video_mode", got[27:25], want.video_mode);
      compare_field("wide_columns", got[28], want.wide_columns);
      compare_field("tall_rows", got[29], want.tall_rows);
      compare_field("matrix_base", got[33:30], want.matrix_base);
      compare_field("glyph_base", got[36:34], want.glyph_base);
      compare_field("padding", got[OutDataW-1:37], 0);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [ActionW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  register_bank_checker bank = new();
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  int cycles = 0;

  video_chip_register_file_core u_top (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .clk_i        (clk_i),
    .rst_ni       (rst_ni)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) bank.check_response(m_axis_tdata);
  end

  initial begin
    while (cycles < CycleLimit) @(posedge clk_i) cycles++;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 13);
        repeat (n) @(negedge clk_i) m_axis_tready <= 1'b0;
      end else begin
        @(negedge clk_i) m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic bus_op_t make_op(logic [ActionW-1:0] act, logic [AddrW-1:0] addr,
                                      logic [7:0] wdata, logic [8:0] line = '0,
                                      logic [7:0] px = '0, logic [7:0] py = '0,
                                      logic [7:0] sh = '0, logic [7:0] bh = '0,
                                      logic [3:0] ev = '0);
    bus_op_t op;
    op.action = act;
    op.addr = addr;
    op.wdata = wdata;
    op.line = line;
    op.pen_x = px;
    op.pen_y = py;
    op.sprite_hits = sh;
    op.backdrop_hits = bh;
    op.irq_events = ev;
    return op;
  endfunction

  task automatic send_item(input bus_op_t op);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op.action;
    s_axis_tdata <= {5'd0, op.irq_events, op.backdrop_hits, op.sprite_hits, op.pen_y,
                     op.pen_x, op.line, op.wdata, op.addr};
    do @(posedge clk_i); while (!s_axis_tready);
    bank.note_request(op);
  endtask

  initial begin
    bus_op_t op;
    int r, n;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    send_item(make_op(ActRead, RegHitSprite, 8'h00));
    send_item(make_op(ActWrite, RegPosFirst, 8'hff));
    send_item(make_op(ActWrite, RegMsbX, 8'hff));
    send_item(make_op(ActRead, RegPosFirst, 8'h00));
    send_item(make_op(ActRead, RegMsbX, 8'h00));
    send_item(make_op(ActWrite, RegPosLast, 8'hff));
    send_item(make_op(ActRead, RegPosLast, 8'h00));
    send_item(make_op(ActWrite, RegCtrlOne, 8'hff));
    send_item(make_op(ActWrite, RegRaster, 8'hff));
    send_item(make_op(ActRead, RegCtrlOne, 8'h00, 9'h1ff));
    send_item(make_op(ActRead, RegRaster, 8'h00, 9'h1ff));
    send_item(make_op(ActRead, RegPenX, 8'h00, 9'h000, 8'hff));
    send_item(make_op(ActRead, RegPenY, 8'h00, 9'h000, 8'h00, 8'hff));
    send_item(make_op(ActWrite, RegIrqEnable, 8'hff));
    send_item(make_op(ActEvent, RegPosFirst, 8'h00, 9'h000, 8'h00, 8'h00, 8'hff, 8'hff, 4'hf));
    send_item(make_op(ActEvent, RegPosFirst, 8'h00, 9'h000, 8'h00, 8'h00, 8'hff, 8'hff, 4'h0));
    send_item(make_op(ActRead, RegIrqLatch, 8'h00));
    send_item(make_op(ActRead, RegHitSprite, 8'h00));
    send_item(make_op(ActRead, RegHitBackdrop, 8'h00));
    send_item(make_op(ActWrite, RegIrqLatch, 8'hff));
    send_item(make_op(ActWrite, RegPenX, 8'h55));
    send_item(make_op(ActWrite, RegUnusedLast, 8'hff));
    send_item(make_op(ActRead, RegUnusedLast, 8'h00));
    send_item(make_op(ActUnknown, RegUnusedLast, 8'hff, 9'h1ff, 8'hff, 8'hff, 8'hff, 8'hff,
                      4'hf));
    send_item(make_op(ActWrite, RegCtrlOne, 8'h00));

    for (int i = 0; i < RandomItems; i++) begin
      calm = (i >= RandomItems - CalmItems);
      if (i == RandomItems / 3) hold_off_req = 1'b1;
      if (i == (2 * RandomItems) / 3) begin
        @(negedge clk_i) s_axis_tvalid <= 1'b0;
        while (bank.outstanding() != 0) @(posedge clk_i);
      end
      if (!calm && $urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 13);
        repeat (n) @(negedge clk_i) s_axis_tvalid <= 1'b0;
      end
      r = $urandom_range(0, 99);
      op.action = (r < 40) ? ActRead : (r < 75) ? ActWrite : (r < 93) ? ActEvent : ActUnknown;
      op.addr = ($urandom_range(0, 99) < 85) ? AddrW'($urandom_range(0, 47))
                                             : AddrW'($urandom_range(0, 63));
      op.wdata = 8'($urandom);
      op.line = 9'($urandom);
      op.pen_x = 8'($urandom);
      op.pen_y = 8'($urandom);
      op.sprite_hits = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00;
      op.backdrop_hits = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00;
      op.irq_events = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0;
      send_item(op);
    end
    @(negedge clk_i) s_axis_tvalid <= 1'b0;

    while (bank.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("summary: %0d reads, %0d writes, %0d events and %0d unknown actions checked",
             bank.n_reads, bank.n_writes, bank.n_events, bank.n_unknown);
    $display("summary: %0d collision register reads, %0d results with the interrupt raised",
             bank.n_hit_reads, bank.n_irq);
    if (bank.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/vcrf_pkg.sv
src/video_chip_register_file_core.sv
src/vcrf_checker.sv
sim/testbench.sv
